@@ rtl/slr_pkg.sv @@
// Shared types, constants and helper functions for the stuffed packet link receiver.
package slr_pkg;

    // Line characters
    localparam logic [7:0] SYNC_CHAR = 8'h16;
    localparam logic [7:0] ESC_CHAR  = 8'h10;

    // Escape codes that follow DLE and the characters they stand for
    localparam logic [7:0] ESC_CODE_SYNC = 8'h53;  // 'S'
    localparam logic [7:0] ESC_CODE_DLE  = 8'h44;  // 'D'
    localparam logic [7:0] ESC_CODE_ETX  = 8'h43;  // 'C'
    localparam logic [7:0] ESC_CODE_XOFF = 8'h73;  // 's'
    localparam logic [7:0] ESC_CODE_XON  = 8'h71;  // 'q'
    localparam logic [7:0] ETX_CHAR      = 8'h03;
    localparam logic [7:0] XOFF_CHAR     = 8'h13;
    localparam logic [7:0] XON_CHAR      = 8'h11;

    // Field widths
    localparam int SUM_W      = 18;
    localparam int RSUM_W     = 12;
    localparam int LEN_W      = 11;
    localparam int SEQ_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Accept modes (any other code accepts both types)
    localparam logic [1:0] MODE_DATA_ONLY = 2'd0;
    localparam logic [1:0] MODE_ACK_ONLY  = 2'd1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEPT_MODE = 1'b0,
        CFG_MAX_LENGTH  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_GOOD       = 3'd0,
        ST_BAD_TYPE   = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_SEQ    = 3'd3,
        ST_BAD_CKSUM  = 3'd4,
        ST_ABORTED    = 3'd5
    } status_t;

    // One result transaction
    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic             pkt_is_data;
        logic [LEN_W-1:0] pkt_length;
        status_t          status;
        logic             send_ack;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_received;
    } res_t;

    // Result plus its valid flag, used between front, queue and back
    typedef struct packed {
        logic valid;
        res_t res;
    } res_slot_t;

    // Undo one DLE escape; unknown codes pass through
    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            ESC_CODE_SYNC: r = SYNC_CHAR;
            ESC_CODE_DLE:  r = ESC_CHAR;
            ESC_CODE_ETX:  r = ETX_CHAR;
            ESC_CODE_XOFF: r = XOFF_CHAR;
            ESC_CODE_XON:  r = XON_CHAR;
            default:       r = c;
        endcase
        return r;
    endfunction

    // Build an end-of-packet report
    function automatic res_t make_report(input logic             is_data,
                                         input logic [LEN_W-1:0] len,
                                         input status_t          st,
                                         input logic [SEQ_W-1:0] seq);
        res_t r;
        logic ack;
        ack            = is_data && (st != ST_ABORTED);
        r.kind         = KIND_REPORT;
        r.data_byte    = '0;
        r.pkt_is_data  = is_data;
        r.pkt_length   = len;
        r.status       = st;
        r.send_ack     = ack;
        r.ack_seq      = ack ? seq : '0;
        r.ack_received = (st == ST_GOOD) && !is_data;
        return r;
    endfunction

endpackage

@@ rtl/slr_ifs.sv @@
// Channel interfaces: received byte input, result output and configuration write.
interface slr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slr_out_if;
    import slr_pkg::*;

    logic             valid;
    logic             ready;
    logic             kind;
    logic [7:0]       data_byte;
    logic             pkt_is_data;
    logic [LEN_W-1:0] pkt_length;
    logic [2:0]       status;
    logic             send_ack;
    logic [SEQ_W-1:0] ack_seq;
    logic             ack_received;

    modport source (output valid, output kind, output data_byte, output pkt_is_data,
                    output pkt_length, output status, output send_ack, output ack_seq,
                    output ack_received, input ready);
    modport sink   (input valid, input kind, input data_byte, input pkt_is_data,
                    input pkt_length, input status, input send_ack, input ack_seq,
                    input ack_received, output ready);
endinterface

interface slr_cfg_if;
    import slr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/slr_front.sv @@
// Front end: takes line bytes, unescapes, parses the frame and produces results.
module slr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_valid,
    input  logic [slr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           q_full,
    output slr_pkg::res_slot_t             push
);
    import slr_pkg::*;

    typedef enum logic [7:0] {
        PH_HUNT = 8'b0000_0001,
        PH_TYPE = 8'b0000_0010,
        PH_LEN1 = 8'b0000_0100,
        PH_SEQ  = 8'b0000_1000,
        PH_DATA = 8'b0001_0000,
        PH_CK0  = 8'b0010_0000,
        PH_CK1  = 8'b0100_0000,
        PH_CK2  = 8'b1000_0000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   frozen_reg, frozen_next;
    logic [RSUM_W-1:0]  rsum_reg, rsum_next;
    logic               type_reg, type_next;
    logic [LEN_W-1:0]   hlen_reg, hlen_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [SEQ_W-1:0]   rx_seq_reg, rx_seq_next;
    logic [SEQ_W-1:0]   tx_seq_reg, tx_seq_next;
    logic [1:0]         mode_reg;
    logic [LEN_W-1:0]   maxlen_reg;

    logic               accept;
    logic [7:0]         ch;
    logic               process;
    logic               rpt;
    status_t            rpt_st;
    logic [LEN_W-1:0]   len;
    logic [SEQ_W-1:0]   want_seq;
    logic [SUM_W-1:0]   want_sum;
    logic [LEN_W-1:0]   left_dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Parse step for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        sum_next    = sum_reg;
        frozen_next = frozen_reg;
        rsum_next   = rsum_reg;
        type_next   = type_reg;
        hlen_next   = hlen_reg;
        left_next   = left_reg;
        rx_seq_next = rx_seq_reg;
        tx_seq_next = tx_seq_reg;
        push        = '0;
        ch          = rx_byte;
        process     = 1'b0;
        rpt         = 1'b0;
        rpt_st      = ST_GOOD;
        len         = {hlen_reg[LEN_W-1:6], rx_byte[5:0]};
        want_seq    = '0;
        want_sum    = '0;
        left_dec    = left_reg - LEN_W'(1);

        if (accept)
        begin
            if (rx_byte == SYNC_CHAR)
            begin
                // Sync restarts the frame; aborts one in progress
                if (phase_reg != PH_HUNT)
                begin
                    push.valid = 1'b1;
                    push.res   = make_report(type_reg, hlen_reg, ST_ABORTED, rx_seq_reg);
                end
                phase_next = PH_TYPE;
                esc_next   = 1'b0;
                sum_next   = '0;
                type_next  = 1'b0;
                hlen_next  = '0;
                left_next  = '0;
            end
            else if (phase_reg != PH_HUNT)
            begin
                sum_next = sum_reg + SUM_W'(rx_byte);
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    ch       = unescape(rx_byte);
                    process  = 1'b1;
                end
                else if (rx_byte == ESC_CHAR)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    process = 1'b1;
                end
            end
        end

        if (process)
        begin
            len = {hlen_reg[LEN_W-1:6], ch[5:0]};
            unique case (phase_reg)
                PH_TYPE:
                begin
                    type_next = ch[5];
                    hlen_next = {ch[4:0], 6'b0};
                    if ((mode_reg == MODE_DATA_ONLY && !ch[5]) ||
                        (mode_reg == MODE_ACK_ONLY && ch[5]))
                    begin
                        hlen_next = '0;
                        rpt       = 1'b1;
                        rpt_st    = ST_BAD_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_LEN1;
                    end
                end
                PH_LEN1:
                begin
                    hlen_next = len;
                    if (len > maxlen_reg)
                    begin
                        rpt    = 1'b1;
                        rpt_st = ST_BAD_LENGTH;
                    end
                    else
                    begin
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:
                begin
                    want_seq = type_reg ? rx_seq_reg : (tx_seq_reg + SEQ_W'(1));
                    if (ch[5:0] != want_seq)
                    begin
                        rpt    = 1'b1;
                        rpt_st = ST_BAD_SEQ;
                    end
                    else
                    begin
                        left_next = hlen_reg;
                        if (hlen_reg == '0)
                        begin
                            frozen_next = sum_next;
                            phase_next  = PH_CK0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    push.valid            = 1'b1;
                    push.res              = '0;
                    push.res.kind         = KIND_DATA;
                    push.res.data_byte    = ch;
                    push.res.pkt_is_data  = type_reg;
                    push.res.pkt_length   = hlen_reg;
                    push.res.status       = ST_GOOD;
                    left_next             = left_dec;
                    if (left_dec == '0)
                    begin
                        frozen_next = sum_next;
                        phase_next  = PH_CK0;
                    end
                end
                PH_CK0:
                begin
                    rsum_next  = {ch[5:0], 6'b0};
                    phase_next = PH_CK1;
                end
                PH_CK1:
                begin
                    rsum_next  = {rsum_reg[RSUM_W-1:6], ch[5:0]};
                    phase_next = PH_CK2;
                end
                PH_CK2:
                begin
                    want_sum = {rsum_reg, ch[5:0]};
                    rpt      = 1'b1;
                    if (frozen_reg != want_sum)
                    begin
                        rpt_st = ST_BAD_CKSUM;
                    end
                    else
                    begin
                        rpt_st = ST_GOOD;
                        if (type_reg)
                        begin
                            rx_seq_next = rx_seq_reg + SEQ_W'(1);
                        end
                        else
                        begin
                            tx_seq_next = tx_seq_reg + SEQ_W'(1);
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Every report other than an abort ends the frame
        if (rpt)
        begin
            push.valid = 1'b1;
            push.res   = make_report(type_next, hlen_next, rpt_st, rx_seq_next);
            phase_next = PH_HUNT;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            esc_reg    <= 1'b0;
            sum_reg    <= '0;
            frozen_reg <= '0;
            rsum_reg   <= '0;
            type_reg   <= 1'b0;
            hlen_reg   <= '0;
            left_reg   <= '0;
            rx_seq_reg <= '0;
            tx_seq_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            sum_reg    <= sum_next;
            frozen_reg <= frozen_next;
            rsum_reg   <= rsum_next;
            type_reg   <= type_next;
            hlen_reg   <= hlen_next;
            left_reg   <= left_next;
            rx_seq_reg <= rx_seq_next;
            tx_seq_reg <= tx_seq_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DATA_ONLY;
            maxlen_reg <= '1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACCEPT_MODE: mode_reg   <= cfg_data[1:0];
                CFG_MAX_LENGTH:  maxlen_reg <= cfg_data;
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    // A pending escape only exists inside a frame
    a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (phase_reg != PH_HUNT))
        else $error("escape pending while hunting");

    // A report that is not an abort returns the parser to hunting
    a_report_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.res.kind == KIND_REPORT && push.res.status != ST_ABORTED)
        |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunt after report");

endmodule

@@ rtl/slr_queue.sv @@
// Short result queue between the parsing front and the output back.
module slr_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  slr_pkg::res_slot_t push,
    output logic               full,
    output slr_pkg::res_slot_t head,
    input  logic               pop
);
    import slr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push.valid && !full;
    assign head.valid = (count_reg != '0);
    assign head.res   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.res;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("result dropped on full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/slr_back.sv @@
// Back end: output register that drains the queue onto the result channel.
module slr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  slr_pkg::res_slot_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output slr_pkg::res_t      out_res
);
    import slr_pkg::*;

    logic out_valid_reg;
    res_t out_res_reg;

    // Load a new result when the register is empty or being taken
    assign pop       = head.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_res_reg <= head.res;
        end
    end

endmodule

@@ rtl/stuffed_packet_link_receiver_top.sv @@
// Each result is written into the queue when its byte is taken, then loaded into the output register.
// Throughput: one byte per cycle unless the queue is full; parse and 18-bit sum add are combinational.
// While the output stalls, QUEUE_DEPTH results plus the output register are buffered;
// input ready drops only when the queue is full.
// Reset: parser hunts for sync, sums and sequences clear, accept_mode 0, max_length 2047.
// Configuration writes complete in the cycle they are presented.
module stuffed_packet_link_receiver_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    slr_in_if.sink    in_ch,
    slr_out_if.source out_ch,
    slr_cfg_if.sink   cfg_ch
);
    import slr_pkg::*;

    res_slot_t push;
    res_slot_t head;
    logic      q_full;
    logic      pop;
    res_t      out_res;

    assign cfg_ch.ready = 1'b1;

    slr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .rx_byte   (in_ch.rx_byte),
        .cfg_valid (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .q_full    (q_full),
        .push      (push)
    );

    slr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    slr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    // Result fields onto the output channel
    assign out_ch.kind         = out_res.kind;
    assign out_ch.data_byte    = out_res.data_byte;
    assign out_ch.pkt_is_data  = out_res.pkt_is_data;
    assign out_ch.pkt_length   = out_res.pkt_length;
    assign out_ch.status       = out_res.status;
    assign out_ch.send_ack     = out_res.send_ack;
    assign out_ch.ack_seq      = out_res.ack_seq;
    assign out_ch.ack_received = out_res.ack_received;

endmodule
